>>> rtl/idq_pkg.sv
`timescale 1ns / 1ps

package idq_pkg;

  // Default storage geometry.
  localparam int IdqDepth     = 128;
  localparam int IdqDataWidth = 32;

  // Configuration register file.
  localparam int CfgWidth  = 8;
  localparam int ApbAddrW  = 3;
  localparam int ApbDataW  = 32;
  localparam logic [CfgWidth-1:0] CapReset = 8'd128;

  // Register indexes (byte address divided by four).
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_INSERT_REAR  = 2'd0,
    OP_DELETE_FRONT = 2'd1,
    OP_DELETE_REAR  = 2'd2,
    OP_QUERY        = 2'd3
  } op_e;

  // Status codes carried by a result transaction.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Configuration seen by the deque controller.
  typedef struct packed {
    logic                clear;
    logic [CfgWidth-1:0] cap;
  } cfg_t;

endpackage

>>> rtl/idq_if.sv
`timescale 1ns / 1ps

// Request channel: one deque operation per transaction.
interface idq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [31:0] key_value;

  modport source (output valid, output opcode, output key_value, input ready);
  modport sink (input valid, input opcode, input key_value, output ready);
endinterface

// Result channel: one status and snapshot per transaction.
interface idq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status_code;
  logic               is_empty;
  logic               is_full;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;

  modport source (
    output valid, output status_code, output is_empty, output is_full,
    output front_value, output rear_value, input ready
  );
  modport sink (
    input valid, input status_code, input is_empty, input is_full,
    input front_value, input rear_value, output ready
  );
endinterface

>>> rtl/idq_ram.sv
`timescale 1ns / 1ps

module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, two registered read ports; reads return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> rtl/idq_ctrl.sv
`timescale 1ns / 1ps

module idq_ctrl #(
  parameter int DEPTH      = idq_pkg::IdqDepth,
  parameter int DATA_WIDTH = idq_pkg::IdqDataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  idq_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] key_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_code_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] rear_value_o
);

  import idq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e                state_q;
  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         tail_q, tail_d;
  logic                  empty_q, empty_d;
  status_e               status_q, status_d;
  logic                  fwd_head_q, fwd_tail_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic                  out_valid_q;
  logic [1:0]            status_code_q;
  logic                  is_empty_q;
  logic                  is_full_q;
  logic [31:0]           front_value_q;
  logic [31:0]           rear_value_q;

  logic [CW-1:0]         cap;
  logic                  accept;
  logic                  full_cur;
  logic                  we;
  logic [63:0]           key_ext;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;
  logic [DATA_WIDTH-1:0] front_word, rear_word;
  logic [63:0]           front_ext, rear_ext;
  logic                  out_free;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i, input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(i) + CW'(1);
    return (s >= c) ? '0 : AW'(s);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i, input logic [CW-1:0] c);
    logic [CW-1:0] m;
    m = c - CW'(1);
    return (i == '0) ? AW'(m) : i - AW'(1);
  endfunction

  // Capacity in use, clamped to one slot at least and the storage depth at most.
  always_comb begin
    if (cfg_i.cap == '0) begin
      cap = CW'(1);
    end else if (32'(cfg_i.cap) > 32'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(cfg_i.cap);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full_cur   = !empty_q && (idx_next(tail_q, cap) == head_q);

  // Stored form of the key: low DATA_WIDTH bits of the zero-extended value.
  assign key_ext = {32'd0, key_value_i};
  assign wdata   = key_ext[DATA_WIDTH-1:0];

  // Pointer update for the operation being accepted.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    status_d = ST_OK;
    we       = 1'b0;
    case (op_e'(opcode_i))
      OP_INSERT_REAR: begin
        if (full_cur) begin
          status_d = ST_OVERFLOW;
        end else begin
          we = accept;
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
          end else begin
            tail_d = idx_next(tail_q, cap);
          end
        end
      end
      OP_DELETE_FRONT, OP_DELETE_REAR: begin
        if (empty_q) begin
          status_d = ST_UNDERFLOW;
        end else if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else if (op_e'(opcode_i) == OP_DELETE_FRONT) begin
          head_d = idx_next(head_q, cap);
        end else begin
          tail_d = idx_prev(tail_q, cap);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Slot storage: the insert writes while both new end slots are read.
  idq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (tail_d),
    .wdata_i   (wdata),
    .re_i      (accept),
    .raddr_a_i (head_d),
    .raddr_b_i (tail_d),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // A slot written in the same cycle is taken from the write data.
  assign front_word = fwd_head_q ? wdata_q : rdata_a;
  assign rear_word  = fwd_tail_q ? wdata_q : rdata_b;
  assign front_ext  = 64'(front_word);
  assign rear_ext   = 64'(rear_word);
  assign out_free   = !out_valid_q || out_ready_i;

  // Control state, pointers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      empty_q       <= 1'b1;
      status_q      <= ST_OK;
      fwd_head_q    <= 1'b0;
      fwd_tail_q    <= 1'b0;
      wdata_q       <= '0;
      out_valid_q   <= 1'b0;
      status_code_q <= '0;
      is_empty_q    <= 1'b1;
      is_full_q     <= 1'b0;
      front_value_q <= '0;
      rear_value_q  <= '0;
    end else begin
      // The result register empties unless a new result is loaded in this cycle.
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.clear) begin
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            head_q     <= head_d;
            tail_q     <= tail_d;
            empty_q    <= empty_d;
            status_q   <= status_d;
            fwd_head_q <= we && (head_d == tail_d);
            fwd_tail_q <= we;
            wdata_q    <= wdata;
            state_q    <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            status_code_q <= status_q;
            is_empty_q    <= empty_q;
            is_full_q     <= full_cur;
            front_value_q <= empty_q ? '1 : front_ext[31:0];
            rear_value_q  <= empty_q ? '1 : rear_ext[31:0];
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_code_o = status_code_q;
  assign is_empty_o    = is_empty_q;
  assign is_full_o     = is_full_q;
  assign front_value_o = front_value_q;
  assign rear_value_o  = rear_value_q;

endmodule

>>> rtl/input_restricted_deque_top.sv
`timescale 1ns / 1ps

// Deque held in a circular buffer of DEPTH slots: values enter at the rear and
// leave from the front or the rear, and every request transaction yields one
// result transaction with a status, the empty and full flags and the front and
// rear values after the operation (all ones when empty). One operation is in
// flight at a time: the slot memory is written and both end slots are read in
// the accept cycle, and the registered read data is formed into the result
// once the output register is free. A result waiting in the output register
// does not hold up the next request. Writing the capacity register over the
// APB port empties the deque; slot contents are kept but no longer visible.

module input_restricted_deque_top #(
  parameter int DEPTH      = idq_pkg::IdqDepth,
  parameter int DATA_WIDTH = idq_pkg::IdqDataWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  idq_in_if.sink                        in_i,
  idq_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idq_pkg::ApbAddrW-1:0]  paddr,
  input  logic [idq_pkg::ApbDataW-1:0]  pwdata,
  output logic [idq_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  import idq_pkg::*;

  logic [CfgWidth-1:0] cap_q;
  logic                reg_sel;
  logic                cap_wr;
  cfg_t                cfg;

  // Register decode: the index is the word address.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_CAPACITY);
  assign cap_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? ApbDataW'(cap_q) : '0;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cap_wr) begin
      cap_q <= pwdata[CfgWidth-1:0];
    end
  end

  assign cfg.clear = cap_wr;
  assign cfg.cap   = cap_q;

  // Deque controller with its slot memory.
  idq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .opcode_i      (in_i.opcode),
    .key_value_i   (in_i.key_value),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_code_o (out_o.status_code),
    .is_empty_o    (out_o.is_empty),
    .is_full_o     (out_o.is_full),
    .front_value_o (out_o.front_value),
    .rear_value_o  (out_o.rear_value)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import idq_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 10;

  // Register map: the capacity register sits at index zero, index one is unmapped.
  localparam logic                SpareReg  = 1'b1;
  localparam logic [ApbAddrW-1:0] CapAddr   = {REG_CAPACITY, 2'b00};
  localparam logic [ApbAddrW-1:0] SpareAddr = {SpareReg, 2'b00};

  typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN} burst_mode_e;

  typedef struct {
    op_e         op;
    logic [31:0] key;
    bit          drain;
  } deque_req_t;

  typedef struct {
    status_e     status;
    logic        empty;
    logic        full;
    logic [31:0] front;
    logic [31:0] rear;
  } deque_snap_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  idq_in_if  req_ch ();
  idq_out_if rsp_ch ();

  input_restricted_deque_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_ch),
    .out_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the deque: slot contents, end pointers, empty flag and capacity.
  logic [31:0] slot_mirror [IdqDepth];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  bit          mirror_empty;
  logic [7:0]  cap_reg;

  deque_req_t  pending_reqs [$];
  deque_snap_t expected_snaps [$];
  int          errors;
  bit          calm;
  int unsigned cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Capacity actually used: zero acts as one, anything above the depth as the depth.
  function automatic int unsigned live_cap();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > IdqDepth) c = IdqDepth;
    return c;
  endfunction

  function automatic int unsigned wrap_inc(int unsigned i, int unsigned c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int unsigned wrap_dec(int unsigned i, int unsigned c);
    return (i == 0) ? c - 1 : i - 1;
  endfunction

  function automatic bit mirror_full(int unsigned c);
    return !mirror_empty && wrap_inc(tail_ptr, c) == head_ptr;
  endfunction

  function automatic void clear_mirror();
    head_ptr     = 0;
    tail_ptr     = 0;
    mirror_empty = 1'b1;
  endfunction

  // Applies one operation to the mirror and returns the snapshot the block must report.
  function automatic deque_snap_t apply_deque_op(deque_req_t r);
    int unsigned c;
    deque_snap_t s;
    c = live_cap();
    s.status = ST_OK;
    case (r.op)
      OP_INSERT_REAR: begin
        if (mirror_full(c)) begin
          s.status = ST_OVERFLOW;
        end else begin
          if (mirror_empty) begin
            head_ptr     = 0;
            tail_ptr     = 0;
            mirror_empty = 1'b0;
          end else begin
            tail_ptr = wrap_inc(tail_ptr, c);
          end
          slot_mirror[tail_ptr] = r.key;
        end
      end
      OP_DELETE_FRONT, OP_DELETE_REAR: begin
        if (mirror_empty) begin
          s.status = ST_UNDERFLOW;
        end else if (head_ptr == tail_ptr) begin
          clear_mirror();
        end else if (r.op == OP_DELETE_FRONT) begin
          head_ptr = wrap_inc(head_ptr, c);
        end else begin
          tail_ptr = wrap_dec(tail_ptr, c);
        end
      end
      default: ;
    endcase
    s.empty = mirror_empty;
    s.full  = mirror_full(c);
    s.front = mirror_empty ? 32'hFFFF_FFFF : slot_mirror[head_ptr];
    s.rear  = mirror_empty ? 32'hFFFF_FFFF : slot_mirror[tail_ptr];
    return s;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(op_e op, logic [31:0] key, bit drain = 1'b0);
    deque_req_t r;
    r.op    = op;
    r.key   = key;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // Random runs that lean toward filling, toward draining, or neither.
  task automatic queue_bursts(int n);
    int          left;
    int          run;
    int          r;
    burst_mode_e mode;
    op_e         op;
    left = n;
    while (left > 0) begin
      run  = $urandom_range(4, 40);
      mode = burst_mode_e'($urandom_range(0, 2));
      for (int i = 0; i < run && left > 0; i++) begin
        r = $urandom_range(0, 99);
        case (mode)
          FILL_RUN:
            op = (r < 75) ? OP_INSERT_REAR : (r < 85) ? OP_DELETE_FRONT :
                 (r < 95) ? OP_DELETE_REAR : OP_QUERY;
          DRAIN_RUN:
            op = (r < 15) ? OP_INSERT_REAR : (r < 55) ? OP_DELETE_FRONT :
                 (r < 95) ? OP_DELETE_REAR : OP_QUERY;
          default:
            op = op_e'($urandom_range(0, 3));
        endcase
        queue_op(op, pick_key(), $urandom_range(0, 199) == 0);
        left--;
      end
    end
  endtask

  // Waits until every queued transaction has been sent and answered.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending_reqs.size() != 0 || expected_snaps.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [ApbAddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Writing the capacity empties the deque; the unmapped register does nothing.
    if (addr == CapAddr) begin
      cap_reg = data[7:0];
      clear_mirror();
    end
  endtask

  task automatic check_capacity_readback();
    logic [ApbDataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CapAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[7:0] !== cap_reg) begin
      errors++;
      $display("%0t: capacity readback expected %0d actual %0d", $time, cap_reg, got[7:0]);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Request driver: presents the oldest pending item and predicts it on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_snaps.push_back(apply_deque_op(pending_reqs[0]));
        void'(pending_reqs.pop_front());
      end
      if (req_ch.valid && !req_ch.ready) begin
        // A transaction on offer stays on offer until it is taken.
      end else if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (pending_reqs[0].drain && expected_snaps.size() != 0) begin
        req_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < IdlePct) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= pending_reqs[0].op;
        req_ch.key_value <= pending_reqs[0].key;
      end
    end
  end

  // Result monitor: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    deque_snap_t want;
    if (rst_ni) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_snaps.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, status %0d", $time,
                   rsp_ch.status_code);
        end else begin
          want = expected_snaps.pop_front();
          check_field("status_code", 32'(want.status), 32'(rsp_ch.status_code));
          check_field("is_empty", 32'(want.empty), 32'(rsp_ch.is_empty));
          check_field("is_full", 32'(want.full), 32'(rsp_ch.is_full));
          check_field("front_value", want.front, rsp_ch.front_value);
          check_field("rear_value", want.rear, rsp_ch.rear_value);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int phase_caps [11];
    phase_caps = '{1, 3, 0, 5, 17, -1, 255, 200, 128, 64, 0};
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_QUERY;
    req_ch.key_value = '0;
    rsp_ch.ready     = 1'b0;
    errors           = 0;
    cycles           = 0;
    calm             = 1'b0;
    cap_reg          = CapReset;
    clear_mirror();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_capacity_readback();

    // Empty deque, extreme values, and deletes from both ends down to empty.
    queue_op(OP_QUERY, 32'h1234_5678);
    queue_op(OP_DELETE_FRONT, 32'h0);
    queue_op(OP_DELETE_REAR, 32'hFFFF_FFFF);
    queue_op(OP_INSERT_REAR, 32'h7FFF_FFFF);
    queue_op(OP_INSERT_REAR, 32'h8000_0000);
    queue_op(OP_INSERT_REAR, 32'hFFFF_FFFF);
    queue_op(OP_INSERT_REAR, 32'h0000_0000);
    queue_op(OP_QUERY, 32'h0);
    queue_op(OP_DELETE_FRONT, 32'h0);
    queue_op(OP_DELETE_REAR, 32'h0);
    queue_op(OP_DELETE_REAR, 32'h0);
    queue_op(OP_DELETE_FRONT, 32'h0);
    queue_op(OP_DELETE_REAR, 32'h0);
    wait_drained();

    // Two slots: full, overflow, wrap of the rear pointer, and emptying from one entry.
    cfg_write(CapAddr, 32'd2);
    check_capacity_readback();
    queue_op(OP_INSERT_REAR, 32'd5);
    queue_op(OP_INSERT_REAR, 32'd6);
    queue_op(OP_INSERT_REAR, 32'd7);
    queue_op(OP_DELETE_FRONT, 32'h0);
    queue_op(OP_INSERT_REAR, 32'd8, 1'b1);
    queue_op(OP_QUERY, 32'h0);
    queue_op(OP_DELETE_REAR, 32'h0);
    queue_op(OP_DELETE_FRONT, 32'h0);
    queue_op(OP_DELETE_FRONT, 32'h0);
    wait_drained();

    // Random phases, each opening with a fill past full and then mixed runs.
    foreach (phase_caps[k]) begin
      if (k == 10) phase_caps[k] = $urandom_range(1, 128);
      calm = (k == 4);
      if (phase_caps[k] < 0) cfg_write(SpareAddr, $urandom);
      else cfg_write(CapAddr, 32'(phase_caps[k]));
      check_capacity_readback();
      repeat (live_cap() + 2) queue_op(OP_INSERT_REAR, pick_key());
      queue_bursts(125);
      wait_drained();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
